FILE: rtl/b64_dec_pkg.sv
// ----------------------------------------------------------------------------
// b64_dec_pkg
// Shared types, codes and the character-to-sextet map of the base64 decoder.
// ----------------------------------------------------------------------------
package b64_dec_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_CHAR   = 2'd1,
      STATUS_BAD_LENGTH = 2'd2
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   // One decoded group or one error, as handed from front to back.
   // emit[0] selects data[23:16], emit[1] data[15:8], emit[2] data[7:0].
   typedef struct packed {
      logic [23:0] data;
      logic [2:0]  emit;
      status_type  status;
      logic        last;
   } job_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s.value = 6'(c - 8'h47);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s.value = 6'(c + 8'h04);
      end else if (c == 8'h2B) begin
         s.value = 6'd62;
      end else if (c == 8'h2F) begin
         s.value = 6'd63;
      end else if (c == PAD_CHAR) begin
         s.value = 6'd0;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

FILE: rtl/b64_dec_front.sv
// ----------------------------------------------------------------------------
// b64_dec_front
// Accepts characters, classifies them and collects groups of four; pushes one
// job per completed group or per error into the queue.
// ----------------------------------------------------------------------------
module b64_dec_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_char_in,
   input  logic                 req_last_in,
   input  logic                 queue_full,
   output logic                 push,
   output b64_dec_pkg::job_type push_job
);

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] acc_ff, acc_in;
   logic        third_pad_ff, third_pad_in;
   logic        discarding_ff, discarding_in;

   b64_dec_pkg::sextet_type sx;
   logic                    is_pad;
   logic                    take;

   assign req_ready = !queue_full;
   assign take      = req_valid && req_ready;
   assign sx        = b64_dec_pkg::sextet_of(req_char_in);
   assign is_pad    = (req_char_in == b64_dec_pkg::PAD_CHAR);

   always_comb begin
      pos_in          = pos_ff;
      acc_in          = acc_ff;
      third_pad_in    = third_pad_ff;
      discarding_in   = discarding_ff;
      push            = 1'b0;
      push_job.data   = {acc_ff, sx.value};
      push_job.emit   = {!is_pad, !third_pad_ff, 1'b1};
      push_job.status = b64_dec_pkg::STATUS_OK;
      push_job.last   = req_last_in;
      if (take) begin
         priority if (discarding_ff) begin
            if (req_last_in) begin
               discarding_in = 1'b0;
               pos_in        = 2'd0;
               acc_in        = 18'd0;
               third_pad_in  = 1'b0;
            end
         end else if (!sx.valid) begin
            pos_in          = 2'd0;
            acc_in          = 18'd0;
            third_pad_in    = 1'b0;
            discarding_in   = !req_last_in;
            push            = 1'b1;
            push_job.data   = 24'd0;
            push_job.emit   = 3'b001;
            push_job.status = b64_dec_pkg::STATUS_BAD_CHAR;
            push_job.last   = 1'b1;
         end else if (pos_ff == 2'd3) begin
            pos_in       = 2'd0;
            acc_in       = 18'd0;
            third_pad_in = 1'b0;
            push         = 1'b1;
         end else if (req_last_in) begin
            pos_in          = 2'd0;
            acc_in          = 18'd0;
            third_pad_in    = 1'b0;
            push            = 1'b1;
            push_job.data   = 24'd0;
            push_job.emit   = 3'b001;
            push_job.status = b64_dec_pkg::STATUS_BAD_LENGTH;
            push_job.last   = 1'b1;
         end else begin
            unique case (pos_ff)
               2'd0: begin
                  acc_in = {sx.value, 12'd0};
               end
               2'd1: begin
                  acc_in[11:6] = sx.value;
               end
               default: begin
                  acc_in[5:0]  = sx.value;
                  third_pad_in = is_pad;
               end
            endcase
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 2'd0;
         acc_ff        <= 18'd0;
         third_pad_ff  <= 1'b0;
         discarding_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         acc_ff        <= acc_in;
         third_pad_ff  <= third_pad_in;
         discarding_ff <= discarding_in;
      end
   end

endmodule

FILE: rtl/b64_dec_queue.sv
// ----------------------------------------------------------------------------
// b64_dec_queue
// Short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module b64_dec_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64_dec_pkg::job_type push_job,
   output logic                 full,
   output logic                 head_valid,
   output b64_dec_pkg::job_type head_job,
   input  logic                 pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64_dec_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != CNT_W'(0));
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/b64_dec_back.sv
// ----------------------------------------------------------------------------
// b64_dec_back
// Takes jobs from the queue and sends their bytes or error one per transfer
// through a registered result stage.
// ----------------------------------------------------------------------------
module b64_dec_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  b64_dec_pkg::job_type head_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_data_byte,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last_out
);

   b64_dec_pkg::job_type work_ff, work_in;
   logic [2:0]           mask_ff, mask_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           data_ff, data_in;
   b64_dec_pkg::status_type status_ff, status_in;
   logic                 last_ff, last_in;

   logic       busy, out_free, emit, final_one;
   logic [2:0] lowest, rest;
   logic [7:0] sel_byte;

   assign busy      = (mask_ff != 3'b000);
   assign out_free  = !valid_ff || rsp_ready;
   assign emit      = busy && out_free;
   assign rest      = mask_ff & ~lowest;
   assign final_one = (rest == 3'b000);
   assign pop       = head_valid && (!busy || (emit && final_one));

   always_comb begin
      priority if (mask_ff[0]) begin
         lowest   = 3'b001;
         sel_byte = work_ff.data[23:16];
      end else if (mask_ff[1]) begin
         lowest   = 3'b010;
         sel_byte = work_ff.data[15:8];
      end else begin
         lowest   = {mask_ff[2], 2'b00};
         sel_byte = work_ff.data[7:0];
      end
   end

   always_comb begin
      work_in   = work_ff;
      mask_in   = mask_ff;
      valid_in  = valid_ff;
      data_in   = data_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (emit) begin
         mask_in   = rest;
         valid_in  = 1'b1;
         data_in   = sel_byte;
         status_in = work_ff.status;
         last_in   = work_ff.last && final_one;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         work_in = head_job;
         mask_in = head_job.emit;
      end
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= 3'b000;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_data_byte = data_ff;
   assign rsp_status    = status_ff;
   assign rsp_last_out  = last_ff;

endmodule

FILE: rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Decodes a base64 character stream into bytes, with error reporting.
// ----------------------------------------------------------------------------
// Input channel req_*: one ASCII character per transfer, req_last_in on the
// final character of a message. Result channel rsp_*: one decoded byte per
// transfer with status and rsp_last_out on the final result of a message.
// Every fourth character of a group yields one to three bytes; an invalid
// character yields one error result and the rest of its message is dropped;
// a message ending mid-group yields one length error.
// Throughput: one character per cycle while the job queue is not full.
// Results leave at most one per cycle from the output register; a job queue
// of QUEUE_DEPTH entries absorbs bursts of errors or byte groups.
// Each job passes through the queue and the back's work register before its
// first result is registered in the output register.
// Reset clears the group, the drop state, the queue and the output register.
// When the receiver stalls, results hold in the output register, the queue
// fills, and req_ready falls once the queue is full.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_last_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last_out
);

   logic                 push, queue_full, head_valid, pop;
   b64_dec_pkg::job_type push_job, head_job;

   b64_dec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_char_in (req_char_in),
      .req_last_in (req_last_in),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   b64_dec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   b64_dec_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_byte (rsp_data_byte),
      .rsp_status    (rsp_status),
      .rsp_last_out  (rsp_last_out)
   );

endmodule

FILE: rtl/b64_dec_checker.sv
// ----------------------------------------------------------------------------
// b64_dec_checker
// Port-level checks on the base64 decoder, bound to its top level.
// ----------------------------------------------------------------------------
module b64_dec_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_char_in,
   input logic       req_last_in,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data_byte,
   input logic [1:0] rsp_status,
   input logic       rsp_last_out
);

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == b64_dec_pkg::STATUS_OK ||
                     rsp_status == b64_dec_pkg::STATUS_BAD_CHAR ||
                     rsp_status == b64_dec_pkg::STATUS_BAD_LENGTH))
      else $error("undefined status code");

   a_error_zero_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != b64_dec_pkg::STATUS_OK) |->
         (rsp_data_byte == 8'd0 && rsp_last_out))
      else $error("error result without zero data or last mark");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_data_byte) && $stable(rsp_status) &&
          $stable(rsp_last_out)))
      else $error("stalled result transfer changed");

endmodule

bind base64_stream_decoder b64_dec_checker u_b64_dec_checker (.*);

FILE: tb/b64_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64_decode_checker
// Watches both channels of the base64 stream decoder, decodes each accepted
// character on its own copy of the group and drop state, and compares every
// result transfer field by field with the oldest expected byte.
// ----------------------------------------------------------------------------
module b64_decode_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_last_in,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_data_byte,
   input  logic [1:0] rsp_status,
   input  logic       rsp_last_out,
   output int         fail_count,
   output int         pending
);

   localparam logic [6:0] NOT_BASE64 = 7'h40;

   typedef struct {
      logic [7:0]              data;
      b64_dec_pkg::status_type status;
      logic                    last;
   } decoded_type;

   decoded_type expected_bytes[$];
   logic [1:0]  group_pos;
   logic [17:0] sextets;
   logic        third_pad;
   logic        dropping;

   // Bit 6 flags a character outside the alphabet.
   function automatic logic [6:0] char_value(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= "A" && c <= "Z") begin
         t = c - "A";
      end else if (c >= "a" && c <= "z") begin
         t = c - "a" + 8'd26;
      end else if (c >= "0" && c <= "9") begin
         t = c - "0" + 8'd52;
      end else if (c == "+") begin
         t = 8'd62;
      end else if (c == "/") begin
         t = 8'd63;
      end else if (c != b64_dec_pkg::PAD_CHAR) begin
         return NOT_BASE64;
      end
      return {1'b0, t[5:0]};
   endfunction

   task automatic restart_group();
      group_pos = 2'd0;
      sextets   = 18'd0;
      third_pad = 1'b0;
   endtask

   task automatic queue_byte(input logic [7:0] d, input b64_dec_pkg::status_type s,
                             input logic l);
      decoded_type e;
      e.data   = d;
      e.status = s;
      e.last   = l;
      expected_bytes.push_back(e);
   endtask

   task automatic decode_char(input logic [7:0] c, input logic l);
      logic [6:0] cv;
      logic [5:0] s1, s2, s3, s4;
      logic       keep2, keep3;
      cv = char_value(c);
      if (dropping) begin
         if (l) begin
            dropping = 1'b0;
            restart_group();
         end
      end else if (cv == NOT_BASE64) begin
         restart_group();
         dropping = !l;
         queue_byte(8'd0, b64_dec_pkg::STATUS_BAD_CHAR, 1'b1);
      end else if (group_pos == 2'd3) begin
         s1    = sextets[17:12];
         s2    = sextets[11:6];
         s3    = sextets[5:0];
         s4    = cv[5:0];
         keep2 = !third_pad;
         keep3 = (c != b64_dec_pkg::PAD_CHAR);
         queue_byte({s1, s2[5:4]}, b64_dec_pkg::STATUS_OK, l && !keep2 && !keep3);
         if (keep2) queue_byte({s2[3:0], s3[5:2]}, b64_dec_pkg::STATUS_OK, l && !keep3);
         if (keep3) queue_byte({s3[1:0], s4}, b64_dec_pkg::STATUS_OK, l);
         restart_group();
      end else begin
         case (group_pos)
            2'd0: sextets = {cv[5:0], 12'd0};
            2'd1: sextets[11:6] = cv[5:0];
            default: begin
               sextets[5:0] = cv[5:0];
               third_pad    = (c == b64_dec_pkg::PAD_CHAR);
            end
         endcase
         if (l) begin
            restart_group();
            queue_byte(8'd0, b64_dec_pkg::STATUS_BAD_LENGTH, 1'b1);
         end else begin
            group_pos = group_pos + 2'd1;
         end
      end
   endtask

   always @(posedge clock) begin
      decoded_type e;
      if (reset) begin
         restart_group();
         dropping   = 1'b0;
         fail_count = 0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected result transfer: data_byte %0h status %0d last_out %0b",
                      rsp_data_byte, rsp_status, rsp_last_out);
               fail_count++;
            end else begin
               e = expected_bytes.pop_front();
               if (rsp_data_byte !== e.data) begin
                  $error("data_byte expected %0h actual %0h", e.data, rsp_data_byte);
                  fail_count++;
               end
               if (rsp_status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_status);
                  fail_count++;
               end
               if (rsp_last_out !== e.last) begin
                  $error("last_out expected %0b actual %0b", e.last, rsp_last_out);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) decode_char(req_char_in, req_last_in);
      end
      pending = expected_bytes.size();
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the base64 stream decoder: a short directed run of
// padding, error and length cases, then random messages, mostly well formed
// with a share of truncated, corrupted and noisy ones, mostly under random stalls.
// ----------------------------------------------------------------------------
module tb;

   localparam int ITEM_TARGET = 450;
   localparam int CYCLE_LIMIT = 100000;
   localparam logic [7:0] PAD_CHAR_TB = b64_dec_pkg::PAD_CHAR;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_char_in = 8'd0;
   logic       req_last_in = 1'b0;
   logic       rsp_ready   = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_data_byte;
   logic [1:0] rsp_status;
   logic       rsp_last_out;
   int         fail_count;
   int         pending;
   int         cycle_count = 0;
   int         items_sent  = 0;
   int         msg_count   = 0;
   logic       jitter      = 1'b1;
   logic [7:0] msg[$];

   always #5 clock = ~clock;

   base64_stream_decoder dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_in   (req_char_in),
      .req_last_in   (req_last_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_byte (rsp_data_byte),
      .rsp_status    (rsp_status),
      .rsp_last_out  (rsp_last_out)
   );

   b64_decode_checker decode_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_in   (req_char_in),
      .req_last_in   (req_last_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_byte (rsp_data_byte),
      .rsp_status    (rsp_status),
      .rsp_last_out  (rsp_last_out),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   always @(negedge clock) begin
      rsp_ready <= jitter ? ($urandom_range(99) >= 27) : 1'b1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [7:0] b64_char(input int unsigned v);
      if (v < 26) return 8'("A" + v);
      if (v < 52) return 8'("a" + (v - 26));
      if (v < 62) return 8'("0" + (v - 52));
      if (v == 62) return "+";
      return "/";
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_char(input logic [7:0] c, input logic l);
      while (jitter && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      req_last_in <= l;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_msg();
      foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);
      msg_count++;
   endtask

   task automatic send_text(input string s);
      msg.delete();
      for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
      send_msg();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // pads: 0 none, 1 fourth is pad, 2 third and fourth, 3 third only
   task automatic build_groups(input int n, input int pads);
      int k;
      msg.delete();
      repeat (n * 4) msg.push_back(b64_char($urandom_range(63)));
      k = msg.size();
      case (pads)
         1: msg[k - 1] = PAD_CHAR_TB;
         2: begin
            msg[k - 1] = PAD_CHAR_TB;
            msg[k - 2] = PAD_CHAR_TB;
         end
         3: msg[k - 2] = PAD_CHAR_TB;
         default: ;
      endcase
   endtask

   initial begin
      int kind;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_text("////");
      send_text("QQ==");
      send_text("QUI=");
      send_text("QQ=B");
      send_text("A;B");
      send_char(8'h80, 1'b1);
      send_char(8'hFF, 1'b1);
      send_text("=z0+");
      send_text("AB");
      drain();

      while (items_sent < ITEM_TARGET) begin
         jitter = !(items_sent >= 200 && items_sent < 300);
         kind = $urandom_range(99);
         if (kind < 60) begin
            build_groups($urandom_range(1, 4), $urandom_range(3));
         end else if (kind < 70) begin
            build_groups($urandom_range(1, 3), 0);
            repeat ($urandom_range(1, 3)) void'(msg.pop_back());
         end else if (kind < 80) begin
            build_groups($urandom_range(1, 3), $urandom_range(3));
            msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
         end else if (kind < 88) begin
            build_groups($urandom_range(1, 3), $urandom_range(3));
            repeat ($urandom_range(1, 3)) msg[$urandom_range(msg.size() - 1)] = PAD_CHAR_TB;
         end else begin
            msg.delete();
            repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(255)));
         end
         send_msg();
         if (msg_count % 40 == 0) drain();
      end

      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/b64_dec_pkg.sv
rtl/b64_dec_front.sv
rtl/b64_dec_queue.sv
rtl/b64_dec_back.sv
rtl/base64_stream_decoder.sv
rtl/b64_dec_checker.sv
tb/b64_decode_checker.sv
tb/tb.sv
